### rtl/core/sbts_pkg.sv
// Shared types and constants for the score based task selector.
// Holds the request and result payload structs and the score constants.
// No dependencies; compile this file first.
package sbts_pkg;

    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned SCORE_W = 34;

    // Score terms: base minus weighted run time plus wait plus weighted nap time.
    localparam logic [SCORE_W-1:0] SCORE_BASE = 34'd1000;

    // Configuration register word indexes.
    localparam logic REG_QUOTA_FILTER = 1'b0;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [TICK_W-1:0]  tick_t;
    typedef logic [SCORE_W-1:0] score_t;

    typedef struct packed {
        slot_t slot_index;
        logic  is_runnable;
        logic  is_throttled;
        tick_t run_ticks;
        tick_t wait_ticks;
        tick_t nap_ticks;
        tick_t pick_count;
        logic  end_of_scan;
    } sbts_req_t;

    typedef struct packed {
        score_t entry_score;
        logic   scan_done;
        logic   winner_found;
        slot_t  winner_slot;
        score_t winner_score;
    } sbts_res_t;

endpackage

### rtl/core/sbts_score.sv
// Score unit of the task selector: 1000 - 5*run + wait + 2*nap, clamped at zero.
// Pure combinational logic; depends on sbts_pkg.
module sbts_score (
    input  sbts_pkg::tick_t  run_ticks,
    input  sbts_pkg::tick_t  wait_ticks,
    input  sbts_pkg::tick_t  nap_ticks,
    output sbts_pkg::score_t score
);
    import sbts_pkg::*;

    // The positive part stays below 2**34 and the negative part below 2**35,
    // so a 36 bit difference never wraps and its top bit is the sign.
    logic [35:0] pos_sum;
    logic [35:0] neg_sum;
    logic [35:0] diff;

    assign pos_sum = {2'b00, SCORE_BASE} + {4'b0000, wait_ticks} + {3'b000, nap_ticks, 1'b0};
    assign neg_sum = {2'b00, run_ticks, 2'b00} + {4'b0000, run_ticks};
    assign diff    = pos_sum - neg_sum;
    assign score   = diff[35] ? '0 : diff[SCORE_W-1:0];

endmodule

### rtl/core/score_based_task_selector_core.sv
// Score based task selector, top level with the request pipeline and the APB port.
// Depends on sbts_pkg and sbts_score.
//
// This block takes one task-table entry per request, in slot order, and returns one
// result per request. Each entry gets a score of 1000 - 5*run_ticks + wait_ticks +
// 2*nap_ticks, computed exactly and clamped at zero, so it fits in 34 bits. An entry
// is eligible when it is runnable and, with quota_filter set, not throttled. The
// first eligible entry of a scan becomes the running best; a later eligible entry
// replaces it when its score is higher, or equal with a smaller pick_count. The
// request that carries end_of_scan takes part in the selection, its result reports
// the winner (or winner_found low when nothing was eligible), and the running best
// clears for the next scan. Only end_of_scan closes a scan; slot numbers are not
// checked. Throughput is one request per clock cycle while res_ready stays high: a
// request is accepted into the input register and its result is loaded into the
// result register once that is empty or being drained. The path that sets
// the clock rate is the score adder chain followed by the 34 bit compare against
// the running best. A held result stalls the input only once the input register is
// also full, so the block holds at most two requests. quota_filter is register 0 at
// byte address 0 of the APB port; write it only while no request is in flight.
module score_based_task_selector_core (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               req_valid,
    output logic               req_ready,
    input  sbts_pkg::sbts_req_t req_item,

    output logic               res_valid,
    input  logic               res_ready,
    output sbts_pkg::sbts_res_t res_item,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sbts_pkg::*;

    // Configuration.
    logic quota_filter_reg;

    // Input register stage.
    logic      req_vld_reg;
    sbts_req_t req_data_reg;

    // Result register stage.
    logic      res_vld_reg;
    sbts_res_t res_data_reg;
    sbts_res_t res_data_next;

    // Running best of the current scan.
    logic   best_valid_reg;
    slot_t  best_slot_reg;
    score_t lead_score_reg;
    tick_t  best_pick_reg;
    logic   best_valid_next;
    slot_t  best_slot_next;
    score_t lead_score_next;
    tick_t  best_pick_next;

    logic   advance;
    logic   eligible;
    logic   better;
    logic   take;
    score_t entry_score;

    // Candidate best after this entry, before the end of scan clears it.
    logic   cand_valid;
    slot_t  cand_slot;
    score_t cand_score;
    tick_t  cand_pick;

    // ------------------------------------------------------------------
    // APB register port. Writes land on the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quota_filter_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_QUOTA_FILTER))
        begin
            quota_filter_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_QUOTA_FILTER)
        begin
            prdata[0] = quota_filter_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A request moves from the input register to the result
    // register whenever the result register is empty or being drained.
    // ------------------------------------------------------------------
    assign advance   = req_vld_reg && (!res_vld_reg || res_ready);
    assign req_ready = !req_vld_reg || advance;
    assign res_valid = res_vld_reg;
    assign res_item  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_data_reg <= req_item;
        end
    end

    // ------------------------------------------------------------------
    // Scoring and selection on the registered request.
    // ------------------------------------------------------------------
    sbts_score u_score (
        .run_ticks  (req_data_reg.run_ticks),
        .wait_ticks (req_data_reg.wait_ticks),
        .nap_ticks  (req_data_reg.nap_ticks),
        .score      (entry_score)
    );

    assign eligible = req_data_reg.is_runnable &&
                      !(quota_filter_reg && req_data_reg.is_throttled);
    assign better   = !best_valid_reg ||
                      (entry_score > lead_score_reg) ||
                      ((entry_score == lead_score_reg) &&
                       (req_data_reg.pick_count < best_pick_reg));
    assign take     = eligible && better;

    assign cand_valid = best_valid_reg || take;
    assign cand_slot  = take ? req_data_reg.slot_index : best_slot_reg;
    assign cand_score = take ? entry_score             : lead_score_reg;
    assign cand_pick  = take ? req_data_reg.pick_count : best_pick_reg;

    always_comb
    begin
        res_data_next             = '0;
        res_data_next.entry_score = entry_score;
        best_valid_next           = cand_valid;
        best_slot_next            = cand_slot;
        lead_score_next           = cand_score;
        best_pick_next            = cand_pick;
        if (req_data_reg.end_of_scan)
        begin
            // The final entry reports the winner and starts a fresh scan.
            res_data_next.scan_done = 1'b1;
            if (cand_valid)
            begin
                res_data_next.winner_found = 1'b1;
                res_data_next.winner_slot  = cand_slot;
                res_data_next.winner_score = cand_score;
            end
            best_valid_next = 1'b0;
            best_slot_next  = '0;
            lead_score_next = '0;
            best_pick_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            best_slot_reg  <= '0;
            lead_score_reg <= '0;
            best_pick_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                res_vld_reg    <= 1'b1;
                best_valid_reg <= best_valid_next;
                best_slot_reg  <= best_slot_next;
                lead_score_reg <= lead_score_next;
                best_pick_reg  <= best_pick_next;
            end
            else if (res_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_data_reg <= res_data_next;
        end
    end

endmodule

### rtl/core/sbts_checker.sv
// Port level checks for the score based task selector, bound to the top level.
// Depends on sbts_pkg and score_based_task_selector_core.
module sbts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input sbts_pkg::sbts_res_t res_item,
    input logic                pready
);
    import sbts_pkg::*;

    // Winner fields carry data only on the result that closes a scan.
    a_winner_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_item.scan_done) |->
            (!res_item.winner_found && (res_item.winner_slot == '0) &&
             (res_item.winner_score == '0)))
        else $error("winner fields set on a result that does not close a scan");

    // A scan with no eligible entry reports a zero winner.
    a_no_winner: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.scan_done && !res_item.winner_found) |->
            ((res_item.winner_slot == '0) && (res_item.winner_score == '0)))
        else $error("winner slot or score set although no winner was found");

    // A stalled result holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_item)))
        else $error("result changed or dropped while stalled");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind score_based_task_selector_core sbts_checker u_sbts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .pready    (pready)
);
